// ----- rtl/lgs_pkg.sv -----
// shared types and constants for the life grid step block
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package lgs_pkg;

   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int CELLS_W = 64;
   localparam int DEPTH   = 64;
   localparam int OP_W    = 2;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_SET  = 2'd0;
   localparam op_type OP_STEP = 2'd1;
   localparam op_type OP_SHOW = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic set_rd;
      logic set_wr;
      logic load0;
      logic load1;
      logic step_go;
      logic emit_rd;
      logic emit_go;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   set_ok;
      logic   out_free;
      logic   at_last;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/lgs_if.sv -----
// request and response channel interfaces for the life grid step block
// depends on lgs_pkg for field widths
`default_nettype none

interface lgs_req_if;
   logic                      valid;
   logic                      ready;
   logic [lgs_pkg::OP_W-1:0]  operation;
   logic [lgs_pkg::ROW_W-1:0] row;
   logic [lgs_pkg::COL_W-1:0] column;

   modport source (output valid, output operation, output row, output column, input ready);
   modport sink (input valid, input operation, input row, input column, output ready);
endinterface

interface lgs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lgs_pkg::ROW_W-1:0]   row_index;
   logic [lgs_pkg::CELLS_W-1:0] row_cells;
   logic                        last;

   modport source (output valid, output row_index, output row_cells, output last, input ready);
   modport sink (input valid, input row_index, input row_cells, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/lgs_ctrl.sv -----
// sequencer for the life grid step block: decodes a word and walks the rows
// depends on lgs_pkg; drives the command struct of lgs_dp
`default_nettype none

module lgs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lgs_pkg::status_type status,
   output lgs_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECODE  = 9'b000000010,
      ST_SET_RD  = 9'b000000100,
      ST_SET_WR  = 9'b000001000,
      ST_LOAD0   = 9'b000010000,
      ST_LOAD1   = 9'b000100000,
      ST_STEP    = 9'b001000000,
      ST_EMIT_RD = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               lgs_pkg::OP_SET:  state_in = status.set_ok ? ST_SET_RD : ST_IDLE;
               lgs_pkg::OP_STEP: state_in = ST_LOAD0;
               lgs_pkg::OP_SHOW: state_in = ST_EMIT_RD;
               default:          state_in = ST_IDLE;
            endcase
         end
         ST_SET_RD: begin
            cmd.set_rd = 1'b1;
            state_in   = ST_SET_WR;
         end
         ST_SET_WR: begin
            cmd.set_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_LOAD0: begin
            cmd.load0 = 1'b1;
            state_in  = ST_LOAD1;
         end
         ST_LOAD1: begin
            cmd.load1 = 1'b1;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (status.out_free) begin
               cmd.step_go = 1'b1;
               if (status.at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_go = 1'b1;
               if (status.at_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_row_moves_need_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step_go || cmd.emit_go) |-> status.out_free)
      else $error("row produced while output register is full");

   a_step_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load1 |=> (state_ff == ST_STEP))
      else $error("window load not followed by step sweep");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ----- rtl/lgs_dp.sv -----
// datapath for the life grid step block: row memory, three-row window,
// next-generation logic and the response register; depends on lgs_pkg
`default_nettype none

module lgs_dp #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lgs_pkg::cmd_type            cmd,
   output lgs_pkg::status_type         status,
   input  lgs_pkg::op_type             req_operation,
   input  logic [lgs_pkg::ROW_W-1:0]   req_row,
   input  logic [lgs_pkg::COL_W-1:0]   req_column,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lgs_pkg::ROW_W-1:0]   rsp_row_index,
   output logic [lgs_pkg::CELLS_W-1:0] rsp_row_cells,
   output logic                        rsp_last
);

   localparam int RW = lgs_pkg::ROW_W;
   localparam int CW = lgs_pkg::CELLS_W;
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);
   localparam logic [RW:0]   ROWS_X   = (RW+1)'(GRID_ROWS);
   localparam logic [lgs_pkg::COL_W:0] COLS_X = (lgs_pkg::COL_W+1)'(GRID_COLS);
   localparam logic [CW-1:0] COL_MASK = {CW{1'b1}} >> (CW - GRID_COLS);

   // row memory with per-row valid bits: a row never written reads dead
   logic [CW-1:0] mem [lgs_pkg::DEPTH];
   logic [lgs_pkg::DEPTH-1:0] valid_ff;

   lgs_pkg::op_type           op_ff;
   logic [RW-1:0]             row_cap_ff;
   logic [lgs_pkg::COL_W-1:0] col_cap_ff;

   logic [CW-1:0] rd_data_ff;
   logic          rd_vld_ff;
   logic [CW-1:0] rd_val;

   logic [CW-1:0] prev_ff, cur_ff;
   logic [CW-1:0] nxt;
   logic [RW-1:0] row_ff;

   logic          rsp_valid_ff;
   logic [RW-1:0] rsp_row_ff;
   logic [CW-1:0] rsp_cells_ff;
   logic          rsp_last_ff;

   logic          rd_en;
   logic [RW-1:0] rd_addr;
   logic          wr_en;
   logic [RW-1:0] wr_addr;
   logic [CW-1:0] wr_data;
   logic [CW-1:0] new_row;
   logic          out_free;
   logic          at_last;

   assign rd_val   = rd_vld_ff ? rd_data_ff : '0;
   assign at_last  = (row_ff == LAST_ROW);
   assign nxt      = at_last ? '0 : rd_val;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.op       = op_ff;
   assign status.set_ok   = ({1'b0, row_cap_ff} < ROWS_X) && ({1'b0, col_cap_ff} < COLS_X);
   assign status.out_free = out_free;
   assign status.at_last  = at_last;

   // B3/S23 rule per column; window rows hold no bits at or above the grid width
   always_comb begin
      logic [CW-1:0] ul, ur, ml, mr, dl, dr;
      logic [3:0]    n;
      ul = prev_ff << 1;
      ur = prev_ff >> 1;
      ml = cur_ff << 1;
      mr = cur_ff >> 1;
      dl = nxt << 1;
      dr = nxt >> 1;
      new_row = '0;
      for (int c = 0; c < CW; c++) begin
         n = 4'(ul[c]) + 4'(prev_ff[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c])
           + 4'(dl[c]) + 4'(nxt[c]) + 4'(dr[c]);
         new_row[c] = (n == 4'd3) || (cur_ff[c] && (n == 4'd2));
      end
      new_row = new_row & COL_MASK;
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (cmd.set_rd) begin
         rd_en   = 1'b1;
         rd_addr = row_cap_ff;
      end else if (cmd.load0 || cmd.emit_rd) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (cmd.load1) begin
         rd_en   = 1'b1;
         rd_addr = RW'(1);
      end else if (cmd.step_go) begin
         // two rows ahead; past the bottom edge the value is masked off
         rd_en   = 1'b1;
         rd_addr = row_ff + RW'(2);
      end else if (cmd.emit_go) begin
         rd_en   = 1'b1;
         rd_addr = row_ff + RW'(1);
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = row_ff;
      wr_data = new_row;
      if (cmd.set_wr) begin
         wr_en   = 1'b1;
         wr_addr = row_cap_ff;
         wr_data = rd_val | (CW'(1) << col_cap_ff);
      end else if (cmd.step_go) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_operation;
         row_cap_ff <= req_row;
         col_cap_ff <= req_column;
      end
      if (cmd.load1) begin
         prev_ff <= '0;
         cur_ff  <= rd_val;
      end else if (cmd.step_go) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt;
      end
      if (cmd.load1 || cmd.emit_rd) begin
         row_ff <= '0;
      end else if (cmd.step_go || cmd.emit_go) begin
         row_ff <= row_ff + RW'(1);
      end
      if (cmd.step_go) begin
         rsp_row_ff   <= row_ff;
         rsp_cells_ff <= new_row;
         rsp_last_ff  <= at_last;
      end else if (cmd.emit_go) begin
         rsp_row_ff   <= row_ff;
         rsp_cells_ff <= rd_val & COL_MASK;
         rsp_last_ff  <= at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step_go || cmd.emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_row_cells = rsp_cells_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_cells_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_cells_ff & ~COL_MASK) == '0))
      else $error("live cell outside grid width");

   a_last_on_bottom_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_row_ff == LAST_ROW)))
      else $error("last flag does not match bottom row");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("written row not marked valid");
`endif

endmodule

`default_nettype wire

// ----- rtl/life_automaton_grid_step.sv -----
// life grid step: a set cell word passes decode, a row read and a row write; an ignored
// set or an unused word passes only decode. step loads the window and then sweeps the rows,
// emit reads row 0 and then sweeps, one row per cycle while the response register is free.
// a stalled response holds the sweep; the next word is taken while the last row waits.
// synchronous reset clears the control state and the row valid bits at once, so the
// grid reads all dead right after reset with no clearing pass.
`default_nettype none

module life_automaton_grid_step #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input logic       clock,
   input logic       reset,
   lgs_req_if.sink   req_ch,
   lgs_rsp_if.source rsp_ch
);

   lgs_pkg::cmd_type    cmd;
   lgs_pkg::status_type status;

   lgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lgs_dp #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_ch.operation),
      .req_row       (req_ch.row),
      .req_column    (req_ch.column),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_row_index (rsp_ch.row_index),
      .rsp_row_cells (rsp_ch.row_cells),
      .rsp_last      (rsp_ch.last)
   );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for life_automaton_grid_step: directed plan, then random words with
// set/step bursts; depends on lgs_pkg, lgs_if and the rtl top level; keeps its own 64x64 grid
module tb;

   localparam lgs_pkg::op_type OP_SPARE = 2'd3;
   localparam int     NUM_ROWS = 64;
   localparam int     NUM_COLS = 64;
   localparam int     RANDOM_ITEMS = 245;
   localparam int     CALM_AFTER = 210;
   localparam int     HOLD_AT = 80;
   localparam int     HOLD_CYCLES = 400;
   localparam int     DRAIN_CYCLES = 80;

   typedef struct {
      logic [lgs_pkg::ROW_W-1:0]   row_index;
      logic [lgs_pkg::CELLS_W-1:0] row_cells;
      logic                        last;
   } grid_row_type;

   typedef struct {
      lgs_pkg::op_type           op;
      logic [lgs_pkg::ROW_W-1:0] row;
      logic [lgs_pkg::COL_W-1:0] column;
      bit                        all_dead;
   } plan_entry_type;

   logic clock;
   logic reset;

   lgs_req_if req_ch();
   lgs_rsp_if rsp_ch();

   life_automaton_grid_step u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   logic [lgs_pkg::CELLS_W-1:0] life_cells [NUM_ROWS];
   grid_row_type       rows_due [$];
   int                 error_count;
   bit                 dead_typed;
   bit                 calm;
   bit                 hold_wanted;
   bit                 hold_spent;
   int                 items_sent;

   // directed plan: corners, a re-set cell, a blinker and an edge block
   plan_entry_type plan [0:20] = '{
      '{lgs_pkg::OP_SHOW, 6'd0,  6'd0,  1'b1},
      '{lgs_pkg::OP_STEP, 6'd0,  6'd0,  1'b1},
      '{OP_SPARE,         6'd63, 6'd63, 1'b0},
      '{lgs_pkg::OP_SET,  6'd0,  6'd0,  1'b0},
      '{lgs_pkg::OP_SET,  6'd63, 6'd63, 1'b0},
      '{lgs_pkg::OP_SET,  6'd0,  6'd63, 1'b0},
      '{lgs_pkg::OP_SET,  6'd63, 6'd0,  1'b0},
      '{lgs_pkg::OP_SET,  6'd0,  6'd0,  1'b0},
      '{lgs_pkg::OP_SHOW, 6'd0,  6'd0,  1'b0},
      '{lgs_pkg::OP_STEP, 6'd0,  6'd0,  1'b1},
      '{lgs_pkg::OP_SET,  6'd10, 6'd20, 1'b0},
      '{lgs_pkg::OP_SET,  6'd10, 6'd21, 1'b0},
      '{lgs_pkg::OP_SET,  6'd10, 6'd22, 1'b0},
      '{lgs_pkg::OP_SET,  6'd0,  6'd30, 1'b0},
      '{lgs_pkg::OP_SET,  6'd0,  6'd31, 1'b0},
      '{lgs_pkg::OP_SET,  6'd1,  6'd30, 1'b0},
      '{lgs_pkg::OP_SET,  6'd1,  6'd31, 1'b0},
      '{lgs_pkg::OP_STEP, 6'd5,  6'd7,  1'b0},
      '{lgs_pkg::OP_STEP, 6'd0,  6'd0,  1'b0},
      '{lgs_pkg::OP_SHOW, 6'd63, 6'd63, 1'b0},
      '{OP_SPARE,         6'd0,  6'd0,  1'b0}
   };

   function automatic logic [lgs_pkg::ROW_W-1:0] pick_row();
      int v;
      v = $urandom_range(0, 63);
      return v[lgs_pkg::ROW_W-1:0];
   endfunction

   function automatic logic [lgs_pkg::COL_W-1:0] pick_col();
      int v;
      v = $urandom_range(0, 63);
      return v[lgs_pkg::COL_W-1:0];
   endfunction

   function automatic bit alive_at(int r, int c);
      if (r < 0 || r >= NUM_ROWS || c < 0 || c >= NUM_COLS) begin
         return 1'b0;
      end
      return life_cells[r][c];
   endfunction

   function automatic void next_generation();
      logic [lgs_pkg::CELLS_W-1:0] fresh [NUM_ROWS];
      int                          n;
      for (int r = 0; r < NUM_ROWS; r++) begin
         fresh[r] = '0;
         for (int c = 0; c < NUM_COLS; c++) begin
            n = 0;
            for (int i = -1; i <= 1; i++) begin
               for (int j = -1; j <= 1; j++) begin
                  if (i != 0 || j != 0) begin
                     n += alive_at(r + i, c + j);
                  end
               end
            end
            if (life_cells[r][c]) begin
               fresh[r][c] = (n == 2 || n == 3);
            end else begin
               fresh[r][c] = (n == 3);
            end
         end
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
         life_cells[r] = fresh[r];
      end
   endfunction

   function automatic void queue_grid(bit typed_dead);
      grid_row_type w;
      for (int r = 0; r < NUM_ROWS; r++) begin
         w.row_index = r[lgs_pkg::ROW_W-1:0];
         w.row_cells = typed_dead ? '0 : life_cells[r];
         w.last = (r == NUM_ROWS - 1);
         rows_due.push_back(w);
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // check result words first, then predict from the request word of the same edge
   always @(posedge clock) begin
      grid_row_type w;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rows_due.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected word: row_index %0d row_cells %h last %b",
                           rsp_ch.row_index, rsp_ch.row_cells, rsp_ch.last);
               end
            end else begin
               w = rows_due.pop_front();
               if (rsp_ch.row_index !== w.row_index || rsp_ch.row_cells !== w.row_cells
                   || rsp_ch.last !== w.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch: row_index exp %0d got %0d, last exp %b got %b",
                              w.row_index, rsp_ch.row_index, w.last, rsp_ch.last);
                     $display("  row_cells exp %h got %h", w.row_cells, rsp_ch.row_cells);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.operation)
               lgs_pkg::OP_SET: begin
                  life_cells[req_ch.row][req_ch.column] = 1'b1;
               end
               lgs_pkg::OP_STEP: begin
                  next_generation();
                  queue_grid(dead_typed);
               end
               lgs_pkg::OP_SHOW: begin
                  queue_grid(dead_typed);
               end
               default: begin
               end
            endcase
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_wanted && !hold_spent) begin
            // long hold-off so the block fills and pushes back on requests
            hold_spent = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // drive one request word and hold it until it is taken
   task automatic put_word(lgs_pkg::op_type op, logic [lgs_pkg::ROW_W-1:0] r,
                           logic [lgs_pkg::COL_W-1:0] c, bit typed);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.row <= r;
      req_ch.column <= c;
      dead_typed <= typed;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic put_counted(lgs_pkg::op_type op, logic [lgs_pkg::ROW_W-1:0] r,
                              logic [lgs_pkg::COL_W-1:0] c);
      put_word(op, r, c, 1'b0);
      items_sent++;
      if (items_sent >= HOLD_AT) begin
         hold_wanted = 1'b1;
      end
      if (items_sent >= CALM_AFTER) begin
         calm = 1'b1;
      end
   endtask

   initial begin
      int base_r;
      int base_c;
      int rr;
      int cc;
      int kind;
      error_count = 0;
      items_sent = 0;
      calm = 1'b0;
      hold_wanted = 1'b0;
      hold_spent = 1'b0;
      dead_typed <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.operation <= lgs_pkg::OP_SET;
      req_ch.row <= '0;
      req_ch.column <= '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         life_cells[r] = '0;
      end
      wait (!reset);
      @(posedge clock);

      for (int i = 0; i < $size(plan); i++) begin
         put_word(plan[i].op, plan[i].row, plan[i].column, plan[i].all_dead);
      end

      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // small cluster, often against an edge, then a few generations
            base_r = ($urandom_range(0, 3) == 0) ? 60 * int'($urandom_range(0, 1))
                                                 : int'($urandom_range(0, 63));
            base_c = ($urandom_range(0, 3) == 0) ? 60 * int'($urandom_range(0, 1))
                                                 : int'($urandom_range(0, 63));
            repeat ($urandom_range(3, 10)) begin
               rr = base_r + int'($urandom_range(0, 4));
               cc = base_c + int'($urandom_range(0, 4));
               if (rr > 63) rr = 63;
               if (cc > 63) cc = 63;
               put_counted(lgs_pkg::OP_SET, rr[lgs_pkg::ROW_W-1:0], cc[lgs_pkg::COL_W-1:0]);
            end
            repeat ($urandom_range(1, 3)) begin
               put_counted(lgs_pkg::OP_STEP, pick_row(), pick_col());
            end
         end else if (kind == 6) begin
            put_counted(lgs_pkg::OP_SHOW, pick_row(), pick_col());
         end else if (kind == 7) begin
            put_counted(lgs_pkg::OP_SET, pick_row(), pick_col());
         end else if (kind == 8) begin
            put_word(OP_SPARE, pick_row(), pick_col(), 1'b0);
         end else begin
            put_counted(lgs_pkg::OP_STEP, pick_row(), pick_col());
         end
      end
      req_ch.valid <= 1'b0;

      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count += rows_due.size();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/lgs_pkg.sv
rtl/lgs_if.sv
rtl/lgs_ctrl.sv
rtl/lgs_dp.sv
rtl/life_automaton_grid_step.sv
bench/tb.sv
